@@ rtl/cmpx_pkg.sv @@
// shared widths and controller/datapath command and status types for the
// complex matrix product unit; no dependencies
package cmpx_pkg;

  // fixed field widths
  localparam int DATA_W = 24;
  localparam int IDX_W  = 4;
  localparam int ACC_W  = 56;
  localparam int PROD_W = 2 * DATA_W;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;    // latch the accepted input transaction
    logic ram_wr;     // write the captured element into the right-matrix store
    logic cnt_clr;    // return the column counter to zero
    logic mac_issue;  // issue one store read and multiply-accumulate
    logic emit_load;  // load one product entry into the output register
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic in_ok;      // input indices are in range
    logic in_kind;    // input kind, 1 for a left-matrix element
    logic cnt_last;   // column counter is at the last column
    logic pipe_busy;  // multiply-accumulate pipeline still holds work
    logic row_end;    // captured element closes its row
    logic out_free;   // output register can take a new entry this cycle
  } status_t;

endpackage

@@ rtl/cmpx_ram.sv @@
// generic simple dual-port ram with one write port and a registered read port
// no dependencies
module cmpx_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 144,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/cmpx_ctrl.sv @@
// controller state machine of the complex matrix product unit
// depends on cmpx_pkg for the command and status types
module cmpx_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  cmpx_pkg::status_t status_i,
  output cmpx_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       accept;

  // input is taken only between items
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && status_i.in_ok) begin
          cmd_o.capture = 1'b1;
          cmd_o.cnt_clr = 1'b1;
          state_d       = status_i.in_kind ? S_MAC : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.ram_wr = 1'b1;
        state_d      = S_IDLE;
      end
      S_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (status_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = status_i.row_end ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (status_i.cnt_last) begin
            cmd_o.cnt_clr = 1'b1;
            state_d       = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/cmpx_datapath.sv @@
// datapath of the complex matrix product unit: input capture, right-matrix
// store, multiply-accumulate pipeline, accumulators and output register
// depends on cmpx_pkg and cmpx_ram
module cmpx_datapath #(
  parameter int FRAC_BITS = 20,
  parameter int DIM       = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cmpx_pkg::cmd_t                       cmd_i,
  output cmpx_pkg::status_t                    status_o,
  input  logic                                 kind_i,
  input  logic        [cmpx_pkg::IDX_W-1:0]    row_index_i,
  input  logic        [cmpx_pkg::IDX_W-1:0]    col_index_i,
  input  logic signed [cmpx_pkg::DATA_W-1:0]   elem_real_i,
  input  logic signed [cmpx_pkg::DATA_W-1:0]   elem_imag_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic        [cmpx_pkg::IDX_W-1:0]    out_row_o,
  output logic        [cmpx_pkg::IDX_W-1:0]    out_col_o,
  output logic signed [cmpx_pkg::DATA_W-1:0]   prod_real_o,
  output logic signed [cmpx_pkg::DATA_W-1:0]   prod_imag_o,
  output logic                                 row_last_o
);

  localparam int DATA_W = cmpx_pkg::DATA_W;
  localparam int IDX_W  = cmpx_pkg::IDX_W;
  localparam int ACC_W  = cmpx_pkg::ACC_W;
  localparam int PROD_W = cmpx_pkg::PROD_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int DEPTH  = DIM * DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int JW     = (DIM > 1) ? $clog2(DIM) : 1;

  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W + 1)'((1 << (DATA_W - 1)) - 1);
  localparam logic signed [ACC_W:0] SAT_MIN  = -SAT_MAX - (ACC_W + 1)'(1);

  // round to nearest with ties up, then clamp to the output range
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] v;
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] c;
    v = $signed({a[ACC_W-1], a}) + RND_HALF;
    s = v >>> FRAC_BITS;
    if (s > SAT_MAX) begin
      c = SAT_MAX;
    end else if (s < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = s;
    end
    return $signed(c[DATA_W-1:0]);
  endfunction

  logic        [IDX_W-1:0]  row_q, col_q;
  logic signed [DATA_W-1:0] re_q, im_q;
  logic        [JW-1:0]     cnt_q, cnt_d;
  logic                     cnt_last;

  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PROD_W-1:0] rd_data;

  logic                     v1_q, v2_q, v3_q;
  logic        [JW-1:0]     j1_q, j2_q, j3_q;
  logic signed [PROD_W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [SUM_W-1:0]  s_re_q, s_im_q;
  logic signed [DATA_W-1:0] b_re, b_im;

  logic signed [ACC_W-1:0] acc_re_q [DIM];
  logic signed [ACC_W-1:0] acc_im_q [DIM];

  logic                     out_valid_q;
  logic        [IDX_W-1:0]  out_row_q, out_col_q;
  logic signed [DATA_W-1:0] prod_re_q, prod_im_q;
  logic                     row_last_q;
  logic                     out_free;

  // status toward the controller
  assign cnt_last = (cnt_q == JW'(DIM - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    status_o           = '0;
    status_o.in_ok     = (row_index_i < IDX_W'(DIM)) && (col_index_i < IDX_W'(DIM));
    status_o.in_kind   = kind_i;
    status_o.cnt_last  = cnt_last;
    status_o.pipe_busy = v1_q || v2_q || v3_q;
    status_o.row_end   = (col_q == IDX_W'(DIM - 1));
    status_o.out_free  = out_free;
  end

  // captured input transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q <= row_index_i;
      col_q <= col_index_i;
      re_q  <= elem_real_i;
      im_q  <= elem_imag_i;
    end
  end

  // column counter shared by the accumulate and emit passes
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.mac_issue || cmd_i.emit_load) begin
      cnt_d = cnt_q + JW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // right-matrix store addressing
  assign wr_addr = ADDR_W'(row_q) * ADDR_W'(DIM) + ADDR_W'(col_q);
  assign rd_addr = ADDR_W'(col_q) * ADDR_W'(DIM) + ADDR_W'(cnt_q);

  cmpx_ram #(
    .WIDTH (PROD_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.ram_wr),
    .wr_addr_i (wr_addr),
    .wr_data_i ({re_q, im_q}),
    .rd_en_i   (cmd_i.mac_issue),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign b_re = $signed(rd_data[PROD_W-1:DATA_W]);
  assign b_im = $signed(rd_data[DATA_W-1:0]);

  // pipeline valid and column tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    j1_q <= cnt_q;
    j2_q <= j1_q;
    j3_q <= j2_q;
  end

  // partial products, one register stage
  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      p_rr_q <= re_q * b_re;
      p_ii_q <= im_q * b_im;
      p_ri_q <= re_q * b_im;
      p_ir_q <= im_q * b_re;
    end
  end

  // complex product terms
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      s_re_q <= SUM_W'(p_rr_q) - SUM_W'(p_ii_q);
      s_im_q <= SUM_W'(p_ri_q) + SUM_W'(p_ir_q);
    end
  end

  // accumulators, wrapping at 56 bits, cleared as each entry is emitted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIM; i++) begin
        acc_re_q[i] <= '0;
        acc_im_q[i] <= '0;
      end
    end else if (v3_q) begin
      acc_re_q[j3_q] <= acc_re_q[j3_q] + ACC_W'(s_re_q);
      acc_im_q[j3_q] <= acc_im_q[j3_q] + ACC_W'(s_im_q);
    end else if (cmd_i.emit_load) begin
      acc_re_q[cnt_q] <= '0;
      acc_im_q[cnt_q] <= '0;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_row_q  <= row_q;
      out_col_q  <= IDX_W'(cnt_q);
      prod_re_q  <= round_sat(acc_re_q[cnt_q]);
      prod_im_q  <= round_sat(acc_im_q[cnt_q]);
      row_last_q <= cnt_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign prod_real_o = prod_re_q;
  assign prod_imag_o = prod_im_q;
  assign row_last_o  = row_last_q;

endmodule

@@ rtl/complex_matrix_product_12x12_unit.sv @@
// top level of the complex matrix product unit
// depends on cmpx_pkg, cmpx_ctrl, cmpx_datapath and cmpx_ram
//
// usage:
//   the input channel (in_valid_i / in_stall_o) carries one matrix element per
//   transaction. kind 0 stores an element of the right matrix, kind 1 feeds an
//   element L[r][k] of the left matrix, which is multiplied against stored row k
//   and summed into DIM complex accumulators, DIM = SPIN_COUNT * COLOR_COUNT.
//   an element with an index of DIM or more is dropped in its accept cycle.
//   a kind 0 element occupies the block through its store write; a kind 1
//   element through one store read and multiply-accumulate per column, then
//   a drain of the read, multiply and add stages.
//   the element with column DIM-1 then emits DIM product entries in column
//   order on the output channel (out_valid_o / out_stall_i), one per cycle
//   through the output register while it is not stalled, and clears the
//   accumulators.
//   a stall on the output holds the entry and pauses the emit pass; the last
//   entry may wait in the output register while the next element is taken.
//   reset clears the accumulators and all control state; the right-matrix
//   store is not cleared and must be written before it is used.
module complex_matrix_product_12x12_unit #(
  parameter int FRAC_BITS   = 20,
  parameter int SPIN_COUNT  = 4,
  parameter int COLOR_COUNT = 3
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic        [cmpx_pkg::IDX_W-1:0]  row_index_i,
  input  logic        [cmpx_pkg::IDX_W-1:0]  col_index_i,
  input  logic signed [cmpx_pkg::DATA_W-1:0] elem_real_i,
  input  logic signed [cmpx_pkg::DATA_W-1:0] elem_imag_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic        [cmpx_pkg::IDX_W-1:0]  out_row_o,
  output logic        [cmpx_pkg::IDX_W-1:0]  out_col_o,
  output logic signed [cmpx_pkg::DATA_W-1:0] prod_real_o,
  output logic signed [cmpx_pkg::DATA_W-1:0] prod_imag_o,
  output logic                               row_last_o
);

  localparam int DIM = SPIN_COUNT * COLOR_COUNT;

  cmpx_pkg::cmd_t    cmd;
  cmpx_pkg::status_t status;

  // sequencing of store writes, accumulate passes and emit passes
  cmpx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // store, arithmetic and output register
  cmpx_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .DIM       (DIM)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (kind_i),
    .row_index_i (row_index_i),
    .col_index_i (col_index_i),
    .elem_real_i (elem_real_i),
    .elem_imag_i (elem_imag_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .prod_real_o (prod_real_o),
    .prod_imag_o (prod_imag_o),
    .row_last_o  (row_last_o)
  );

endmodule

@@ verif/cmpx_tb_pkg.sv @@
// shared sizes, element kinds and sample extremes for the complex matrix
// product testbench; depends on cmpx_pkg for the field widths
`timescale 1ns / 1ps

package cmpx_tb_pkg;

  // block configuration under test
  localparam int FRAC_BITS   = 20;
  localparam int SPIN_COUNT  = 4;
  localparam int COLOR_COUNT = 3;
  localparam int DIM         = SPIN_COUNT * COLOR_COUNT;

  // element kinds on the input channel
  localparam logic KIND_RIGHT = 1'b0;
  localparam logic KIND_LEFT  = 1'b1;

  // extremes of one Q4.20 sample
  localparam logic signed [cmpx_pkg::DATA_W-1:0] MAX_SAMPLE = 24'sh7FFFFF;
  localparam logic signed [cmpx_pkg::DATA_W-1:0] MIN_SAMPLE = 24'sh800000;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

endpackage

@@ verif/cmpx_product_checker.sv @@
// product checker: watches both channels, predicts every product entry and
// compares it with the block output; depends on cmpx_pkg and cmpx_tb_pkg
`timescale 1ns / 1ps

module cmpx_product_checker
  import cmpx_pkg::*;
  import cmpx_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     kind_i,
  input  logic        [IDX_W-1:0]  row_index_i,
  input  logic        [IDX_W-1:0]  col_index_i,
  input  logic signed [DATA_W-1:0] elem_real_i,
  input  logic signed [DATA_W-1:0] elem_imag_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic        [IDX_W-1:0]  out_row_i,
  input  logic        [IDX_W-1:0]  out_col_i,
  input  logic signed [DATA_W-1:0] prod_real_i,
  input  logic signed [DATA_W-1:0] prod_imag_i,
  input  logic                     row_last_i,
  output int                       mismatch_count_o,
  output int                       pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic        [IDX_W-1:0]  row;
    logic        [IDX_W-1:0]  col;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     last;
  } product_entry_t;

  // own copy of the right matrix and the row accumulators
  logic signed [DATA_W-1:0] right_re [DIM*DIM];
  logic signed [DATA_W-1:0] right_im [DIM*DIM];
  logic signed [ACC_W-1:0]  sum_re   [DIM];
  logic signed [ACC_W-1:0]  sum_im   [DIM];

  product_entry_t expected_products [$];

  // shift out the fraction with ties toward plus infinity, then clamp
  function automatic logic signed [DATA_W-1:0] round_saturate(
    input logic signed [ACC_W-1:0] acc
  );
    longint v;
    v = acc;
    v = (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (v > OUT_MAX) begin
      v = OUT_MAX;
    end else if (v < OUT_MIN) begin
      v = OUT_MIN;
    end
    return DATA_W'(v);
  endfunction

  // apply one accepted element: store it, or multiply-accumulate a stored row
  task automatic accumulate_element(
    input logic                     kind,
    input logic        [IDX_W-1:0]  row,
    input logic        [IDX_W-1:0]  col,
    input logic signed [DATA_W-1:0] re,
    input logic signed [DATA_W-1:0] im
  );
    longint         ar;
    longint         ai;
    longint         br;
    longint         bi;
    int             idx;
    product_entry_t entry;
    if (row >= DIM || col >= DIM) return;
    if (kind == KIND_RIGHT) begin
      right_re[row*DIM + col] = re;
      right_im[row*DIM + col] = im;
      return;
    end
    ar = re;
    ai = im;
    for (int j = 0; j < DIM; j++) begin
      idx = col*DIM + j;
      br = right_re[idx];
      bi = right_im[idx];
      // 56-bit registers wrap on the truncating assignment
      sum_re[j] = sum_re[j] + (ar*br - ai*bi);
      sum_im[j] = sum_im[j] + (ar*bi + ai*br);
    end
    if (col != DIM - 1) return;
    // closing column: emit the whole row and clear
    for (int j = 0; j < DIM; j++) begin
      entry.row  = row;
      entry.col  = IDX_W'(j);
      entry.re   = round_saturate(sum_re[j]);
      entry.im   = round_saturate(sum_im[j]);
      entry.last = (j == DIM - 1);
      expected_products.push_back(entry);
      sum_re[j] = '0;
      sum_im[j] = '0;
    end
  endtask

  // sample both channels at the clock edge
  always @(posedge clk_i) begin
    product_entry_t want;
    if (!rst_ni) begin
      for (int j = 0; j < DIM; j++) begin
        sum_re[j] = '0;
        sum_im[j] = '0;
      end
      expected_products.delete();
      mismatch_count_o = 0;
    end else begin
      // output transaction against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_products.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= MAX_REPORTS) begin
            $display("unexpected product: row %0d col %0d re %0d im %0d last %0b",
                     out_row_i, out_col_i, prod_real_i, prod_imag_i, row_last_i);
          end
        end else begin
          want = expected_products.pop_front();
          if (out_row_i !== want.row || out_col_i !== want.col ||
              prod_real_i !== want.re || prod_imag_i !== want.im ||
              row_last_i !== want.last) begin
            mismatch_count_o++;
            if (mismatch_count_o <= MAX_REPORTS) begin
              $display("product mismatch: expected row %0d col %0d re %0d im %0d last %0b",
                       want.row, want.col, want.re, want.im, want.last);
              $display("                  actual   row %0d col %0d re %0d im %0d last %0b",
                       out_row_i, out_col_i, prod_real_i, prod_imag_i, row_last_i);
            end
          end
        end
      end
      // input transaction updates the prediction
      if (in_valid_i && !in_stall_i) begin
        accumulate_element(kind_i, row_index_i, col_index_i, elem_real_i, elem_imag_i);
      end
    end
    pending_o = expected_products.size();
  end

endmodule

@@ verif/testbench.sv @@
// top of the complex matrix product testbench: clock, reset, stimulus and
// verdict; depends on cmpx_pkg, cmpx_tb_pkg and cmpx_product_checker
`timescale 1ns / 1ps

module testbench;
  import cmpx_pkg::*;
  import cmpx_tb_pkg::*;

  localparam int RANDOM_TARGET  = 145;
  localparam int PHASE_B_START  = 205;
  localparam int PHASE_C_START  = 260;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 4 * (DIM + 6);

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic                     kind_i      = KIND_RIGHT;
  logic        [IDX_W-1:0]  row_index_i = '0;
  logic        [IDX_W-1:0]  col_index_i = '0;
  logic signed [DATA_W-1:0] elem_real_i = '0;
  logic signed [DATA_W-1:0] elem_imag_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic        [IDX_W-1:0]  out_row_o;
  logic        [IDX_W-1:0]  out_col_o;
  logic signed [DATA_W-1:0] prod_real_o;
  logic signed [DATA_W-1:0] prod_imag_o;
  logic                     row_last_o;

  int mismatch_count;
  int pending_products;
  int accepted_elements = 0;
  int sender_idle_pct   = 28;
  int receiver_idle_pct = 88;
  int hold_left         = 0;
  int quiet_cycles      = 0;
  bit hold_request      = 1'b0;

  complex_matrix_product_12x12_unit #(
    .FRAC_BITS  (FRAC_BITS),
    .SPIN_COUNT (SPIN_COUNT),
    .COLOR_COUNT(COLOR_COUNT)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .row_index_i(row_index_i),
    .col_index_i(col_index_i),
    .elem_real_i(elem_real_i),
    .elem_imag_i(elem_imag_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .prod_real_o(prod_real_o),
    .prod_imag_o(prod_imag_o),
    .row_last_o (row_last_o)
  );

  cmpx_product_checker product_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .kind_i          (kind_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .elem_real_i     (elem_real_i),
    .elem_imag_i     (elem_imag_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_i       (out_row_o),
    .out_col_i       (out_col_o),
    .prod_real_i     (prod_real_o),
    .prod_imag_i     (prod_imag_o),
    .row_last_i      (row_last_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_products)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample value biased toward the extremes and small magnitudes
  function automatic logic signed [DATA_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return MAX_SAMPLE;
      1: return MIN_SAMPLE;
      2: return DATA_W'(int'($urandom_range(0, 2047)) - 1024);
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // offer one element after a random idle gap and wait for its transaction
  task automatic send_element(
    input logic                     kind,
    input logic        [IDX_W-1:0]  row,
    input logic        [IDX_W-1:0]  col,
    input logic signed [DATA_W-1:0] re,
    input logic signed [DATA_W-1:0] im
  );
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    kind_i      <= kind;
    row_index_i <= row;
    col_index_i <= col;
    elem_real_i <= re;
    elem_imag_i <= im;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    accepted_elements++;
    // idle profile follows the run's progress
    if (accepted_elements == PHASE_B_START) begin
      sender_idle_pct   = 88;
      receiver_idle_pct = 28;
    end else if (accepted_elements == PHASE_C_START) begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
  endtask

  // output stall: random, or one long counted hold when requested
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
        out_stall_i  <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    int   random_elements;
    int   row;
    int   roll;
    logic kind;
    int   rrow;
    int   rcol;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill the whole right matrix so every later read hits written entries
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        send_element(KIND_RIGHT, IDX_W'(r), IDX_W'(c), pick_sample(), pick_sample());
      end
    end

    // saturation both ways on a row closed by its last column alone
    send_element(KIND_RIGHT, 4'd11, 4'd0, MAX_SAMPLE, '0);
    send_element(KIND_RIGHT, 4'd11, 4'd1, MIN_SAMPLE, '0);
    send_element(KIND_RIGHT, 4'd11, 4'd11, MIN_SAMPLE, MIN_SAMPLE);
    send_element(KIND_LEFT, 4'd7, 4'd11, MAX_SAMPLE, MAX_SAMPLE);

    // half-way ties round toward plus infinity
    send_element(KIND_RIGHT, 4'd10, 4'd0, 24'sd524288, -24'sd524288);
    send_element(KIND_LEFT, 4'd2, 4'd10, 24'sd1, '0);
    send_element(KIND_LEFT, 4'd2, 4'd11, '0, '0);

    // repeated and skipped columns with extreme values on row zero
    send_element(KIND_LEFT, 4'd0, 4'd0, MIN_SAMPLE, MAX_SAMPLE);
    send_element(KIND_LEFT, 4'd0, 4'd5, MAX_SAMPLE, MIN_SAMPLE);
    send_element(KIND_LEFT, 4'd0, 4'd5, MIN_SAMPLE, MIN_SAMPLE);
    send_element(KIND_LEFT, 4'd0, 4'd11, MAX_SAMPLE, MAX_SAMPLE);

    // right matrix rewritten while a left row is in progress
    send_element(KIND_LEFT, 4'd5, 4'd4, pick_sample(), pick_sample());
    send_element(KIND_RIGHT, 4'd4, 4'd3, MAX_SAMPLE, MIN_SAMPLE);
    send_element(KIND_LEFT, 4'd5, 4'd4, pick_sample(), pick_sample());
    send_element(KIND_LEFT, 4'd5, 4'd11, pick_sample(), pick_sample());

    // out of range indices are dropped
    send_element(KIND_RIGHT, 4'd12, 4'd0, MAX_SAMPLE, MAX_SAMPLE);
    send_element(KIND_RIGHT, 4'd0, 4'd15, MIN_SAMPLE, MIN_SAMPLE);
    send_element(KIND_LEFT, 4'd15, 4'd11, MAX_SAMPLE, MIN_SAMPLE);
    send_element(KIND_LEFT, 4'd3, 4'd12, MIN_SAMPLE, MAX_SAMPLE);

    // bottom row with the most negative element
    send_element(KIND_LEFT, 4'd11, 4'd11, MIN_SAMPLE, MIN_SAMPLE);

    // random traffic, starting with a long output hold to back up the block
    hold_request    = 1'b1;
    random_elements = 0;
    while (random_elements < RANDOM_TARGET) begin
      if ($urandom_range(0, 4) != 0) begin
        // well-formed row with random content and the odd irregularity
        row = $urandom_range(0, DIM - 1);
        for (int c = 0; c < DIM - 1; c++) begin
          roll = $urandom_range(0, 15);
          if (roll == 0) continue;
          if (roll == 1) begin
            send_element(KIND_RIGHT, IDX_W'($urandom_range(0, DIM - 1)),
                         IDX_W'($urandom_range(0, DIM - 1)), pick_sample(), pick_sample());
            random_elements++;
          end
          send_element(KIND_LEFT, IDX_W'(row), IDX_W'(c), pick_sample(), pick_sample());
          random_elements++;
          if (roll == 2) begin
            send_element(KIND_LEFT, IDX_W'(row), IDX_W'(c), pick_sample(), pick_sample());
            random_elements++;
          end
        end
        send_element(KIND_LEFT, IDX_W'(row), IDX_W'(DIM - 1), pick_sample(), pick_sample());
        random_elements++;
      end else begin
        // noise over the full index range
        kind = 1'($urandom_range(0, 1));
        rrow = $urandom_range(0, 15);
        rcol = $urandom_range(0, 15);
        send_element(kind, IDX_W'(rrow), IDX_W'(rcol), pick_sample(), pick_sample());
        if (rrow < DIM && rcol < DIM) random_elements++;
      end
    end
    in_valid_i <= 1'b0;

    // drain outstanding products, then let the pipeline settle
    @(posedge clk_i);
    while (pending_products != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && pending_products == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
